// ===== hw/rtl/e2q_pkg.sv =====
// e2q_pkg: shared constants, types and arithmetic helpers for the euler to quaternion core
// no dependencies; imported by every module of the block

package e2q_pkg;

  localparam int E2Q_ANGLE_BITS     = 16;
  localparam int E2Q_COMPONENT_BITS = 16;

  localparam int E2Q_CORDIC_STEPS = 30;
  localparam int E2Q_LANES        = 3;
  localparam int E2Q_ROT_W        = 34;
  localparam int E2Q_Q30_W        = 32;

  // lane order follows the input field order
  localparam int E2Q_LANE_BANK     = 0;
  localparam int E2Q_LANE_HEADING  = 1;
  localparam int E2Q_LANE_ATTITUDE = 2;

  localparam logic signed [E2Q_ROT_W-1:0] E2Q_CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [E2Q_ROT_W-1:0] E2Q_ONE_Q30     = 34'sd1073741824;

  // atan(2^-i), 2^32 equals 2*pi
  localparam logic signed [E2Q_ROT_W-1:0] E2Q_ATAN [E2Q_CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  typedef logic signed [E2Q_Q30_W-1:0] e2q_q30_t;

  typedef struct packed {
    logic signed [E2Q_ROT_W-1:0] x;
    logic signed [E2Q_ROT_W-1:0] y;
    logic signed [E2Q_ROT_W-1:0] z;
  } e2q_rot_t;

  typedef e2q_rot_t [E2Q_LANES-1:0] e2q_rot_lanes_t;

  // clamp a cordic output to [-1.0, 1.0] in q30
  function automatic e2q_q30_t e2q_clamp_unit(input logic signed [E2Q_ROT_W-1:0] v);
    e2q_q30_t r;
    if (v > E2Q_ONE_Q30) begin
      r = E2Q_ONE_Q30[E2Q_Q30_W-1:0];
    end else if (v < -E2Q_ONE_Q30) begin
      r = e2q_q30_t'(-E2Q_ONE_Q30);
    end else begin
      r = v[E2Q_Q30_W-1:0];
    end
    return r;
  endfunction

  // q30 times q30, rounded half up back to q30
  function automatic e2q_q30_t e2q_mulq(input e2q_q30_t a, input e2q_q30_t b);
    logic signed [2*E2Q_Q30_W-1:0] p;
    p = a * b + 64'sd536870912;
    return e2q_q30_t'(p >>> 30);
  endfunction

endpackage

// ===== hw/rtl/e2q_cordic_cell.sv =====
// e2q_cordic_cell: one cordic rotation step for all three angle lanes, with its own
// pipeline register and valid/ready link; depends on e2q_pkg

module e2q_cordic_cell import e2q_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  e2q_rot_lanes_t rot_i,
  output logic           ready_o,
  output logic           valid_o,
  output e2q_rot_lanes_t rot_o,
  input  logic           ready_i
);

  logic           valid_q;
  e2q_rot_lanes_t rot_d, rot_q;

  always_comb begin
    for (int l = 0; l < E2Q_LANES; l++) begin
      if (!rot_i[l].z[E2Q_ROT_W-1]) begin
        rot_d[l].x = rot_i[l].x - (rot_i[l].y >>> STEP);
        rot_d[l].y = rot_i[l].y + (rot_i[l].x >>> STEP);
        rot_d[l].z = rot_i[l].z - E2Q_ATAN[STEP];
      end else begin
        rot_d[l].x = rot_i[l].x + (rot_i[l].y >>> STEP);
        rot_d[l].y = rot_i[l].y - (rot_i[l].x >>> STEP);
        rot_d[l].z = rot_i[l].z + E2Q_ATAN[STEP];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

// ===== hw/rtl/e2q_quat_calc.sv =====
// e2q_quat_calc: clamp, pairwise and triple products, sums and output rounding
// four registered stages with valid/ready links; depends on e2q_pkg

module e2q_quat_calc import e2q_pkg::*; #(
  parameter int COMPONENT_BITS = E2Q_COMPONENT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  e2q_rot_lanes_t                   rot_i,
  output logic                             ready_o,
  output logic                             valid_o,
  output logic signed [COMPONENT_BITS-1:0] quat_w_o,
  output logic signed [COMPONENT_BITS-1:0] quat_x_o,
  output logic signed [COMPONENT_BITS-1:0] quat_y_o,
  output logic signed [COMPONENT_BITS-1:0] quat_z_o,
  input  logic                             ready_i
);

  localparam int F      = COMPONENT_BITS - 1;
  localparam int SH     = (F < 30) ? 30 - F : 0;
  localparam int RND_SH = (F < 30) ? 29 - F : 0;
  localparam int SUM_W  = E2Q_Q30_W + 1;
  localparam int CNV_W  = E2Q_Q30_W + 3;

  function automatic logic signed [COMPONENT_BITS-1:0] to_out(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [CNV_W-1:0] r;
    logic signed [CNV_W-1:0] hi;
    logic signed [CNV_W-1:0] lo;
    if (F < 30) begin
      r = (CNV_W'(v) + (CNV_W'(1) <<< RND_SH)) >>> SH;
    end else if (F == 30) begin
      r = CNV_W'(v);
    end else begin
      r = CNV_W'(v) <<< 1;
    end
    hi = (CNV_W'(1) <<< F) - CNV_W'(1);
    lo = -hi - CNV_W'(1);
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r[COMPONENT_BITS-1:0];
  endfunction

  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // stage a: clamped cosines and sines
  e2q_q30_t c1_q, s1_q, c2_q, s2_q, c3_q, s3_q;
  // stage b: pairwise products, bank terms carried along
  e2q_q30_t cc_q, ss_q, sc_q, cs_q, b_c3_q, b_s3_q;
  // stage c: eight triple products
  e2q_q30_t t_ccc_q, t_sss_q, t_ssc_q, t_ccs_q, t_scc_q, t_css_q, t_csc_q, t_scs_q;
  // stage d: output register
  logic signed [COMPONENT_BITS-1:0] w_q, x_q, y_q, z_q;

  assign rdy_d   = !d_vld_q || ready_i;
  assign rdy_c   = !c_vld_q || rdy_d;
  assign rdy_b   = !b_vld_q || rdy_c;
  assign rdy_a   = !a_vld_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (rdy_a) a_vld_q <= valid_i;
      if (rdy_b) b_vld_q <= a_vld_q;
      if (rdy_c) c_vld_q <= b_vld_q;
      if (rdy_d) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      c1_q <= e2q_clamp_unit(rot_i[E2Q_LANE_HEADING].x);
      s1_q <= e2q_clamp_unit(rot_i[E2Q_LANE_HEADING].y);
      c2_q <= e2q_clamp_unit(rot_i[E2Q_LANE_ATTITUDE].x);
      s2_q <= e2q_clamp_unit(rot_i[E2Q_LANE_ATTITUDE].y);
      c3_q <= e2q_clamp_unit(rot_i[E2Q_LANE_BANK].x);
      s3_q <= e2q_clamp_unit(rot_i[E2Q_LANE_BANK].y);
    end
    if (rdy_b && a_vld_q) begin
      cc_q   <= e2q_mulq(c1_q, c2_q);
      ss_q   <= e2q_mulq(s1_q, s2_q);
      sc_q   <= e2q_mulq(s1_q, c2_q);
      cs_q   <= e2q_mulq(c1_q, s2_q);
      b_c3_q <= c3_q;
      b_s3_q <= s3_q;
    end
    if (rdy_c && b_vld_q) begin
      t_ccc_q <= e2q_mulq(cc_q, b_c3_q);
      t_sss_q <= e2q_mulq(ss_q, b_s3_q);
      t_ssc_q <= e2q_mulq(ss_q, b_c3_q);
      t_ccs_q <= e2q_mulq(cc_q, b_s3_q);
      t_scc_q <= e2q_mulq(sc_q, b_c3_q);
      t_css_q <= e2q_mulq(cs_q, b_s3_q);
      t_csc_q <= e2q_mulq(cs_q, b_c3_q);
      t_scs_q <= e2q_mulq(sc_q, b_s3_q);
    end
    if (rdy_d && c_vld_q) begin
      w_q <= to_out(SUM_W'(t_ccc_q) - SUM_W'(t_sss_q));
      x_q <= to_out(SUM_W'(t_ssc_q) + SUM_W'(t_ccs_q));
      y_q <= to_out(SUM_W'(t_scc_q) + SUM_W'(t_css_q));
      z_q <= to_out(SUM_W'(t_csc_q) - SUM_W'(t_scs_q));
    end
  end

  assign valid_o  = d_vld_q;
  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

// ===== hw/rtl/euler_to_quaternion_core.sv =====
// a transaction is registered in each cordic cell, then in each product/output stage
// throughput: one transaction per cycle while unstalled, set by the 30-cell cordic chain
// and the four product/output stages, each of which takes a new transaction every cycle
// stalls pass back only through full stages; empty stages keep filling while the output waits
// reset (rst_ni low, asynchronous) clears every stage valid bit; data registers are not reset
module euler_to_quaternion_core import e2q_pkg::*; #(
  parameter int ANGLE_BITS     = E2Q_ANGLE_BITS,
  parameter int COMPONENT_BITS = E2Q_COMPONENT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [ANGLE_BITS-1:0]     bank_angle_i,
  input  logic signed [ANGLE_BITS-1:0]     heading_angle_i,
  input  logic signed [ANGLE_BITS-1:0]     attitude_angle_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [COMPONENT_BITS-1:0] quat_w_o,
  output logic signed [COMPONENT_BITS-1:0] quat_x_o,
  output logic signed [COMPONENT_BITS-1:0] quat_y_o,
  output logic signed [COMPONENT_BITS-1:0] quat_z_o
);

  // binary angle scaled so that 2^32 is a full turn, then halved
  localparam int HALF_SH = 32 - ANGLE_BITS;

  logic signed [ANGLE_BITS-1:0] ang [E2Q_LANES];
  logic signed [31:0]           ang_ext [E2Q_LANES];
  logic signed [31:0]           ang_half [E2Q_LANES];

  // chain links: index k feeds cell k, index E2Q_CORDIC_STEPS feeds the product stages
  e2q_rot_lanes_t rot_chain [E2Q_CORDIC_STEPS+1];
  logic           vld_chain [E2Q_CORDIC_STEPS+1];
  logic           rdy_chain [E2Q_CORDIC_STEPS+1];

  assign ang[E2Q_LANE_BANK]     = bank_angle_i;
  assign ang[E2Q_LANE_HEADING]  = heading_angle_i;
  assign ang[E2Q_LANE_ATTITUDE] = attitude_angle_i;

  // seed every lane: x at the cordic gain, y at zero, z at the half angle
  always_comb begin
    for (int l = 0; l < E2Q_LANES; l++) begin
      ang_ext[l]        = 32'(ang[l]) <<< HALF_SH;
      ang_half[l]       = ang_ext[l] >>> 1;
      rot_chain[0][l].x = E2Q_CORDIC_GAIN;
      rot_chain[0][l].y = '0;
      rot_chain[0][l].z = E2Q_ROT_W'(ang_half[l]);
    end
  end

  assign vld_chain[0] = in_valid_i;
  assign in_stall_o   = !rdy_chain[0];

  // one cell per cordic step, each rotating all three lanes at once
  for (genvar k = 0; k < E2Q_CORDIC_STEPS; k++) begin : g_cell
    e2q_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld_chain[k]),
      .rot_i  (rot_chain[k]),
      .ready_o(rdy_chain[k]),
      .valid_o(vld_chain[k+1]),
      .rot_o  (rot_chain[k+1]),
      .ready_i(rdy_chain[k+1])
    );
  end

  // clamp, products, sums and output register
  e2q_quat_calc #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_chain[E2Q_CORDIC_STEPS]),
    .rot_i   (rot_chain[E2Q_CORDIC_STEPS]),
    .ready_o (rdy_chain[E2Q_CORDIC_STEPS]),
    .valid_o (out_valid_o),
    .quat_w_o(quat_w_o),
    .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o),
    .quat_z_o(quat_z_o),
    .ready_i (!out_stall_i)
  );

endmodule

// ===== hw/rtl/e2q_checker.sv =====
// e2q_checker: port-level assertions for euler_to_quaternion_core, bound to the top level
// depends on e2q_pkg for parameter defaults

module e2q_checker import e2q_pkg::*; #(
  parameter int ANGLE_BITS     = E2Q_ANGLE_BITS,
  parameter int COMPONENT_BITS = E2Q_COMPONENT_BITS
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic signed [ANGLE_BITS-1:0]     bank_angle_i,
  input logic signed [ANGLE_BITS-1:0]     heading_angle_i,
  input logic signed [ANGLE_BITS-1:0]     attitude_angle_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [COMPONENT_BITS-1:0] quat_w_o,
  input logic signed [COMPONENT_BITS-1:0] quat_x_o,
  input logic signed [COMPONENT_BITS-1:0] quat_y_o,
  input logic signed [COMPONENT_BITS-1:0] quat_z_o
);

  // no result may be offered once reset has held over a clock edge
  a_reset_empty: assert property (@(posedge clk_i) (!rst_ni ##1 !rst_ni) |-> !out_valid_o)
    else $error("result offered during reset");

  // input back-pressure only ever comes from a stalled, occupied output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result withdrawn");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(quat_w_o) && $stable(quat_x_o) && $stable(quat_y_o) && $stable(quat_z_o)))
    else $error("stalled result changed");

endmodule

bind euler_to_quaternion_core e2q_checker #(
  .ANGLE_BITS    (ANGLE_BITS),
  .COMPONENT_BITS(COMPONENT_BITS)
) u_e2q_checker (.*);
